/* src/lmts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode timing package
// Shared widths, timing periods, register indexes and mode codes.
// ----------------------------------------------------------------------------
package lmts_pkg;

  localparam int unsigned FrameCycles = 70224;
  localparam int unsigned LineCycles  = 456;

  localparam int unsigned FrameW  = 17;
  localparam int unsigned LineW   = 9;
  localparam int unsigned CyclesW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [1:0] {
    MODE_HBLANK   = 2'd0,
    MODE_VBLANK   = 2'd1,
    MODE_SEARCH   = 2'd2,
    MODE_TRANSFER = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_VBLANK_AFTER   = 3'd0,
    REG_HBLANK_AFTER   = 3'd1,
    REG_TRANSFER_AFTER = 3'd2,
    REG_SEARCH_AFTER   = 3'd3,
    REG_VBLANK_STAT_EN = 3'd4,
    REG_HBLANK_STAT_EN = 3'd5,
    REG_SEARCH_STAT_EN = 3'd6,
    REG_DISPLAY_EN     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic  draw_request;
    logic  stat_request;
    logic  vblank_request;
    logic  video_memory_open;
    logic  sprite_table_open;
    mode_e mode;
  } result_t;

  localparam logic [FrameW-1:0] VblankAfterRst   = FrameW'(65663);
  localparam logic [LineW-1:0]  HblankAfterRst   = LineW'(251);
  localparam logic [LineW-1:0]  TransferAfterRst = LineW'(79);
  localparam logic [LineW-1:0]  SearchAfterRst   = LineW'(0);

endpackage

/* src/lcd_mode_timing_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode timing sequencer
// Advances the frame and line counters and derives the display mode,
// memory access flags and interrupt and draw requests.
// ----------------------------------------------------------------------------
// Each accepted transaction's result is registered in the output register.
// Throughput: one transaction per cycle unless stalled, set by the single
// counter update and threshold compare between state and output registers.
// Reset: counters clear, the mode returns to horizontal blank with both
// memories open, and the registers take their documented reset values.
module lcd_mode_timing_sequencer
  import lmts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: cycles[7:0]
  input  logic [CyclesW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: mode[1:0], sprite_table_open[2], video_memory_open[3],
  // vblank_request[4], stat_request[5], draw_request[6], zero[7]
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic [FrameW-1:0] vblank_after_q;
  logic [LineW-1:0]  hblank_after_q, transfer_after_q, search_after_q;
  logic              vblank_stat_en_q, hblank_stat_en_q, search_stat_en_q;
  logic              display_en_q;

  logic [FrameW-1:0] frame_q, frame_d;
  logic [LineW-1:0]  line_q, line_d;
  mode_e             mode_q, mode_d;
  logic              sprite_q, sprite_d, video_q, video_d;
  logic              valid_q;
  result_t           res_q, res_d;

  logic [FrameW:0]   frame_sum;
  logic [LineW:0]    line_sum;
  logic              accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vblank_after_q   <= VblankAfterRst;
      hblank_after_q   <= HblankAfterRst;
      transfer_after_q <= TransferAfterRst;
      search_after_q   <= SearchAfterRst;
      vblank_stat_en_q <= 1'b0;
      hblank_stat_en_q <= 1'b0;
      search_stat_en_q <= 1'b0;
      display_en_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_VBLANK_AFTER:   vblank_after_q   <= cfg_data_i[FrameW-1:0];
        REG_HBLANK_AFTER:   hblank_after_q   <= cfg_data_i[LineW-1:0];
        REG_TRANSFER_AFTER: transfer_after_q <= cfg_data_i[LineW-1:0];
        REG_SEARCH_AFTER:   search_after_q   <= cfg_data_i[LineW-1:0];
        REG_VBLANK_STAT_EN: vblank_stat_en_q <= cfg_data_i[0];
        REG_HBLANK_STAT_EN: hblank_stat_en_q <= cfg_data_i[0];
        REG_SEARCH_STAT_EN: search_stat_en_q <= cfg_data_i[0];
        REG_DISPLAY_EN:     display_en_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // The frame period is a whole number of lines, so the line position can
  // wrap on its own alongside the frame counter.
  always_comb begin
    frame_sum = {1'b0, frame_q} + (FrameW + 1)'(s_axis_tdata);
    if (frame_sum >= (FrameW + 1)'(FrameCycles)) begin
      frame_d = FrameW'(frame_sum - (FrameW + 1)'(FrameCycles));
    end else begin
      frame_d = frame_sum[FrameW-1:0];
    end
    line_sum = {1'b0, line_q} + (LineW + 1)'(s_axis_tdata);
    if (line_sum >= (LineW + 1)'(LineCycles)) begin
      line_d = LineW'(line_sum - (LineW + 1)'(LineCycles));
    end else begin
      line_d = line_sum[LineW-1:0];
    end
  end

  always_comb begin
    mode_d   = mode_q;
    sprite_d = sprite_q;
    video_d  = video_q;
    res_d    = '0;
    priority if (frame_d > vblank_after_q) begin
      mode_d               = MODE_VBLANK;
      sprite_d             = 1'b1;
      video_d              = 1'b1;
      res_d.vblank_request = 1'b1;
      res_d.stat_request   = vblank_stat_en_q;
    end else if (line_d > hblank_after_q) begin
      mode_d             = MODE_HBLANK;
      sprite_d           = 1'b1;
      video_d            = 1'b1;
      res_d.stat_request = hblank_stat_en_q;
    end else if (line_d > transfer_after_q) begin
      mode_d             = MODE_TRANSFER;
      sprite_d           = 1'b0;
      video_d            = 1'b0;
      res_d.draw_request = display_en_q;
    end else if (line_d > search_after_q) begin
      mode_d             = MODE_SEARCH;
      sprite_d           = 1'b0;
      video_d            = 1'b1;
      res_d.stat_request = search_stat_en_q;
    end else begin
    end
    res_d.mode              = mode_d;
    res_d.sprite_table_open = sprite_d;
    res_d.video_memory_open = video_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q  <= '0;
      line_q   <= '0;
      mode_q   <= MODE_HBLANK;
      sprite_q <= 1'b1;
      video_q  <= 1'b1;
      valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        frame_q  <= frame_d;
        line_q   <= line_d;
        mode_q   <= mode_d;
        sprite_q <= sprite_d;
        video_q  <= video_d;
        valid_q  <= 1'b1;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {1'b0, res_q};

endmodule

/* src/lmts_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode timing checker
// Port-level checks on the result stream of the sequencer.
// ----------------------------------------------------------------------------
module lmts_checker
  import lmts_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic [CfgIdxW-1:0]  cfg_index_i,
  input logic [CfgDataW-1:0] cfg_data_i,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [CyclesW-1:0]  s_axis_tdata,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic unused_inputs;
  assign unused_inputs = cfg_we_i ^ (^cfg_index_i) ^ (^cfg_data_i) ^ (^s_axis_tdata);

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  // An accepted transaction always leads to a result in the next cycle.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted transaction produced no result");

  a_vblank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[4]) |->
      (m_axis_tdata[1:0] == MODE_VBLANK && m_axis_tdata[3:2] == 2'b11))
    else $error("vertical blank request outside vertical blank");

  a_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[6]) |->
      (m_axis_tdata[1:0] == MODE_TRANSFER && m_axis_tdata[3:2] == 2'b00))
    else $error("draw request outside pixel transfer");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tdata[7] && (m_axis_tdata[3] || !m_axis_tdata[2])))
    else $error("inconsistent access flags");

endmodule

bind lcd_mode_timing_sequencer lmts_checker u_lmts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_index_i   (cfg_index_i),
  .cfg_data_i    (cfg_data_i),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD mode timing sequencer testbench
// Feeds elapsed-cycle counts through the stream input and checks every status
// word against a cycle-accurate model of the frame and line counters, the
// mode priority and the request logic. A directed part covers the extremes
// and the held-mode case, then random phases cover several register settings
// with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import lmts_pkg::*;

  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned PhaseItems     = 190;
  localparam int unsigned SettleCycles   = 4;
  localparam int unsigned HoldOffCycles  = 400;

  class mode_timing_scoreboard;
    logic [FrameW-1:0] vblank_after;
    logic [LineW-1:0]  hblank_after;
    logic [LineW-1:0]  transfer_after;
    logic [LineW-1:0]  search_after;
    logic              vblank_stat_en;
    logic              hblank_stat_en;
    logic              search_stat_en;
    logic              display_en;

    logic [FrameW-1:0] frame_time;
    logic [LineW-1:0]  line_pos;
    mode_e             cur_mode;
    logic              sprite_open;
    logic              video_open;

    result_t           expected_status[$];
    int unsigned       mismatches;

    function new();
      vblank_after   = VblankAfterRst;
      hblank_after   = HblankAfterRst;
      transfer_after = TransferAfterRst;
      search_after   = SearchAfterRst;
      vblank_stat_en = 1'b0;
      hblank_stat_en = 1'b0;
      search_stat_en = 1'b0;
      display_en     = 1'b0;
      frame_time     = '0;
      line_pos       = '0;
      cur_mode       = MODE_HBLANK;
      sprite_open    = 1'b1;
      video_open     = 1'b1;
      mismatches     = 0;
    endfunction

    function void apply_register(reg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_VBLANK_AFTER:   vblank_after   = data[FrameW-1:0];
        REG_HBLANK_AFTER:   hblank_after   = data[LineW-1:0];
        REG_TRANSFER_AFTER: transfer_after = data[LineW-1:0];
        REG_SEARCH_AFTER:   search_after   = data[LineW-1:0];
        REG_VBLANK_STAT_EN: vblank_stat_en = data[0];
        REG_HBLANK_STAT_EN: hblank_stat_en = data[0];
        REG_SEARCH_STAT_EN: search_stat_en = data[0];
        REG_DISPLAY_EN:     display_en     = data[0];
        default: ;
      endcase
    endfunction

    function void note_elapsed(logic [CyclesW-1:0] elapsed);
      int unsigned t;
      result_t     r;
      t = frame_time;
      t = (t + elapsed) % FrameCycles;
      frame_time = t[FrameW-1:0];
      line_pos   = LineW'(t % LineCycles);
      r = '0;
      if (frame_time > vblank_after) begin
        cur_mode         = MODE_VBLANK;
        sprite_open      = 1'b1;
        video_open       = 1'b1;
        r.vblank_request = 1'b1;
        r.stat_request   = vblank_stat_en;
      end else if (line_pos > hblank_after) begin
        cur_mode       = MODE_HBLANK;
        sprite_open    = 1'b1;
        video_open     = 1'b1;
        r.stat_request = hblank_stat_en;
      end else if (line_pos > transfer_after) begin
        cur_mode       = MODE_TRANSFER;
        sprite_open    = 1'b0;
        video_open     = 1'b0;
        r.draw_request = display_en;
      end else if (line_pos > search_after) begin
        cur_mode       = MODE_SEARCH;
        sprite_open    = 1'b0;
        video_open     = 1'b1;
        r.stat_request = search_stat_en;
      end
      r.mode              = cur_mode;
      r.sprite_table_open = sprite_open;
      r.video_memory_open = video_open;
      expected_status.push_back(r);
    endfunction

    function void check_status(logic [OutDataW-1:0] tdata);
      result_t got;
      result_t want;
      got = result_t'(tdata[6:0]);
      if (expected_status.size() == 0) begin
        if (mismatches < 10) begin
          $display("Unexpected status transaction: tdata %h", tdata);
        end
        mismatches++;
        return;
      end
      want = expected_status.pop_front();
      if (got.mode !== want.mode ||
          got.sprite_table_open !== want.sprite_table_open ||
          got.video_memory_open !== want.video_memory_open ||
          got.vblank_request !== want.vblank_request ||
          got.stat_request !== want.stat_request ||
          got.draw_request !== want.draw_request ||
          tdata[7] !== 1'b0) begin
        if (mismatches < 10) begin
          $display("Status mismatch: expected mode %0d spr %b vid %b vbl %b stat %b draw %b",
                   want.mode, want.sprite_table_open, want.video_memory_open,
                   want.vblank_request, want.stat_request, want.draw_request);
          $display("                 actual   mode %0d spr %b vid %b vbl %b stat %b draw %b pad %b",
                   got.mode, got.sprite_table_open, got.video_memory_open,
                   got.vblank_request, got.stat_request, got.draw_request, tdata[7]);
        end
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_status.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [CyclesW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  mode_timing_scoreboard sb;
  int unsigned           tx_idle_pct;
  int unsigned           rx_idle_pct;
  bit                    rx_hold_req;

  lcd_mode_timing_sequencer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_elapsed(input logic [CyclesW-1:0] elapsed);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= elapsed;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_elapsed(elapsed);
  endtask

  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.apply_register(idx, data);
  endtask

  task automatic program_timing(input logic [CfgDataW-1:0] vb, input logic [CfgDataW-1:0] hb,
                                input logic [CfgDataW-1:0] tr, input logic [CfgDataW-1:0] se,
                                input logic [CfgDataW-1:0] ven, input logic [CfgDataW-1:0] hen,
                                input logic [CfgDataW-1:0] sen, input logic [CfgDataW-1:0] den);
    write_reg(REG_VBLANK_AFTER, vb);
    write_reg(REG_HBLANK_AFTER, hb);
    write_reg(REG_TRANSFER_AFTER, tr);
    write_reg(REG_SEARCH_AFTER, se);
    write_reg(REG_VBLANK_STAT_EN, ven);
    write_reg(REG_HBLANK_STAT_EN, hen);
    write_reg(REG_SEARCH_STAT_EN, sen);
    write_reg(REG_DISPLAY_EN, den);
    cfg_we_i <= 1'b0;
  endtask

  // Receiver: checks each status transaction and applies random or long back-pressure.
  initial begin : status_sink
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_status(m_axis_tdata);
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned n;
    n = 0;
    forever begin
      @(posedge clk_i);
      n++;
      if (n > CycleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [CyclesW-1:0] held_batch [9] = '{8'd0, 8'd1, 8'd0, 8'd79, 8'd171,
                                           8'd1, 8'd203, 8'd1, 8'd255};
    logic [CyclesW-1:0] req_batch  [6] = '{8'd0, 8'd201, 8'd1, 8'd80, 8'd8, 8'd255};
    logic [CyclesW-1:0] top_batch  [3] = '{8'd255, 8'd128, 8'd0};
    logic [CyclesW-1:0] zero_batch [2] = '{8'd255, 8'd255};
    logic [CyclesW-1:0] elapsed;
    int unsigned        roll;
    int unsigned        se;
    int unsigned        tr;
    int unsigned        hb;

    sb          = new();
    tx_idle_pct = 20;
    rx_idle_pct = 75;
    rx_hold_req = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= REG_VBLANK_AFTER;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: walk more than one line, including steps where no threshold is passed.
    foreach (held_batch[i]) send_elapsed(held_batch[i]);
    drain_and_settle();

    // Every request enabled, with an early vertical blank.
    program_timing(17'd1000, 17'd251, 17'd79, 17'd0, 17'd1, 17'd1, 17'd1, 17'd1);
    foreach (req_batch[i]) send_elapsed(req_batch[i]);
    drain_and_settle();

    // Thresholds beyond the periods: no mode is ever chosen.
    program_timing(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF,
                   17'h1FFFE, 17'h1FFFE, 17'h1FFFE, 17'h1FFFE);
    foreach (top_batch[i]) send_elapsed(top_batch[i]);
    drain_and_settle();

    program_timing(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0);
    foreach (zero_batch[i]) send_elapsed(zero_batch[i]);
    drain_and_settle();

    for (int p = 0; p < 6; p++) begin
      se = $urandom_range(0, 150);
      tr = $urandom_range(se, 300);
      hb = $urandom_range(tr, 455);
      case (p)
        0: program_timing(17'd65663, 17'd251, 17'd79, 17'd0,
                          17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom));
        1: program_timing(17'($urandom_range(0, 4000)), 17'(hb), 17'(tr), 17'(se),
                          17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom));
        2: program_timing(17'd0, 17'd0, 17'd0, 17'd0, 17'd1, 17'd1, 17'd1, 17'd1);
        3: program_timing(17'h1FFFF, 17'($urandom), 17'($urandom), 17'($urandom),
                          17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom));
        4: program_timing(17'($urandom_range(60000, 70223)), 17'(hb), 17'(tr), 17'(se),
                          17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom));
        default: program_timing(17'd70223, 17'd455, 17'(tr), 17'd0,
                                17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom));
      endcase
      if (p < 2) begin
        tx_idle_pct = 20;
        rx_idle_pct = 75;
      end else if (p < 4) begin
        tx_idle_pct = 75;
        rx_idle_pct = 20;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (p == 4) rx_hold_req = 1'b1;
      for (int i = 0; i < PhaseItems; i++) begin
        roll = $urandom_range(0, 9);
        case (roll)
          0:       elapsed = 8'd0;
          1:       elapsed = 8'd255;
          2, 3:    elapsed = 8'($urandom_range(0, 255));
          default: elapsed = 8'($urandom_range(150, 255));
        endcase
        send_elapsed(elapsed);
      end
      drain_and_settle();
    end

    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
